FILE: hw/rtl/apq_pkg.sv
// shared types and constants for the array priority queue
package apq_pkg;

    localparam int VALUE_W    = 32;
    localparam int PRI_W      = 16;
    localparam int FUNC_W     = 2;
    localparam int STATUS_W   = 2;
    localparam int ECOUNT_W   = 4;
    localparam int S_TDATA_W  = 56;
    localparam int M_TDATA_W  = 56;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_INSERT = 2'd0,
        FUNC_PEEK   = 2'd1,
        FUNC_DELETE = 2'd2
    } func_t;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK    = 2'd0,
        STATUS_FULL  = 2'd1,
        STATUS_EMPTY = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SCAN,
        ST_DONE
    } state_t;

endpackage

FILE: hw/rtl/apq_cell.sv
// one queue slot: holds an entry, shifts down on delete, passes the search token on
module apq_cell #(
    parameter int IDX_W = 3,
    parameter int INDEX = 0
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          occ,
    input  logic                          wr_en,
    input  logic [apq_pkg::VALUE_W-1:0]   wr_val,
    input  logic [apq_pkg::PRI_W-1:0]     wr_pri,
    input  logic                          sh_en,
    input  logic [apq_pkg::VALUE_W-1:0]   sh_val,
    input  logic [apq_pkg::PRI_W-1:0]     sh_pri,
    output logic [apq_pkg::VALUE_W-1:0]   ent_val,
    output logic [apq_pkg::PRI_W-1:0]     ent_pri,
    input  logic                          tok_in_valid,
    input  logic                          tok_in_found,
    input  logic [apq_pkg::VALUE_W-1:0]   tok_in_val,
    input  logic [apq_pkg::PRI_W-1:0]     tok_in_pri,
    input  logic [IDX_W-1:0]              tok_in_idx,
    output logic                          tok_out_valid,
    output logic                          tok_out_found,
    output logic [apq_pkg::VALUE_W-1:0]   tok_out_val,
    output logic [apq_pkg::PRI_W-1:0]     tok_out_pri,
    output logic [IDX_W-1:0]              tok_out_idx
);

    logic [apq_pkg::VALUE_W-1:0] val_reg, val_next;
    logic [apq_pkg::PRI_W-1:0]   pri_reg, pri_next;
    logic                        tv_reg, tv_next;
    logic                        tf_reg, tf_next;
    logic [apq_pkg::VALUE_W-1:0] tval_reg, tval_next;
    logic [apq_pkg::PRI_W-1:0]   tpri_reg, tpri_next;
    logic [IDX_W-1:0]            tidx_reg, tidx_next;
    logic                        take;

    always_comb begin
        val_next = val_reg;
        pri_next = pri_reg;
        if (wr_en) begin
            val_next = wr_val;
            pri_next = wr_pri;
        end else if (sh_en) begin
            val_next = sh_val;
            pri_next = sh_pri;
        end
    end

    // later slots win ties
    assign take = occ && (!tok_in_found || (pri_reg >= tok_in_pri));

    always_comb begin
        tv_next   = tok_in_valid;
        tf_next   = tok_in_found;
        tval_next = tok_in_val;
        tpri_next = tok_in_pri;
        tidx_next = tok_in_idx;
        if (take) begin
            tf_next   = 1'b1;
            tval_next = val_reg;
            tpri_next = pri_reg;
            tidx_next = IDX_W'(INDEX);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tv_reg <= 1'b0;
        end else begin
            tv_reg <= tv_next;
        end
    end

    always_ff @(posedge aclk) begin
        val_reg  <= val_next;
        pri_reg  <= pri_next;
        tf_reg   <= tf_next;
        tval_reg <= tval_next;
        tpri_reg <= tpri_next;
        tidx_reg <= tidx_next;
    end

    assign ent_val       = val_reg;
    assign ent_pri       = pri_reg;
    assign tok_out_valid = tv_reg;
    assign tok_out_found = tf_reg;
    assign tok_out_val   = tval_reg;
    assign tok_out_pri   = tpri_reg;
    assign tok_out_idx   = tidx_reg;

endmodule

FILE: hw/rtl/array_priority_queue.sv
// top level of the array priority queue: request sequencer and row of slots
// Bounded priority queue of DEPTH entries kept in arrival order in a row of
// slots. One request is handled at a time. Insert, an unused operation code,
// and peek or delete on an empty queue load their result into the output
// register from the execute state, once that register is free. For peek and
// delete on a non-empty queue a search token walks the whole row of slots,
// one slot per cycle, and on delete every slot above the winner then shifts
// down together as the result is loaded. The next request is taken the
// cycle after a result is loaded. A result still waiting in the output
// register does not stop the next request being taken, but holds back
// that request's result.
// Among equal priorities the most recently stored entry is served.
module array_priority_queue #(
    parameter int DEPTH = 8
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // func[1:0], element_value[33:2], priority_req[49:34], zero pad
    input  logic [apq_pkg::S_TDATA_W-1:0]   s_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // status[1:0], out_value[33:2], out_priority[49:34], entry_count[53:50], zero pad
    output logic [apq_pkg::M_TDATA_W-1:0]   m_tdata
);

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int VW    = apq_pkg::VALUE_W;
    localparam int PW    = apq_pkg::PRI_W;

    apq_pkg::state_t state_reg, state_next;

    apq_pkg::func_t  op_reg;
    logic [VW-1:0]   val_reg;
    logic [PW-1:0]   pri_reg;
    logic [CNT_W-1:0] count_reg, count_next;

    logic [VW-1:0]   best_val_reg;
    logic [PW-1:0]   best_pri_reg;
    logic [IDX_W-1:0] best_idx_reg;

    logic            m_valid_reg, m_valid_next;
    logic [apq_pkg::M_TDATA_W-1:0] m_data_reg, m_data_next;

    logic            take_in, imm_fin, start_scan, done_fin, out_free, is_scan;
    logic            do_insert, do_shift, full;

    apq_pkg::status_t res_status;
    logic [VW-1:0]   res_val;
    logic [PW-1:0]   res_pri;
    logic [CNT_W-1:0] res_count;
    logic [CNT_W+3:0] res_count_ext;

    logic [DEPTH:0]  tok_valid, tok_found;
    logic [VW-1:0]   tok_val [DEPTH+1];
    logic [PW-1:0]   tok_pri [DEPTH+1];
    logic [IDX_W-1:0] tok_idx [DEPTH+1];
    logic [VW-1:0]   ent_val [DEPTH];
    logic [PW-1:0]   ent_pri [DEPTH];

    assign out_free = !m_valid_reg || m_tready;
    assign full     = (count_reg == CNT_W'(DEPTH));
    assign is_scan  = ((op_reg == apq_pkg::FUNC_PEEK) || (op_reg == apq_pkg::FUNC_DELETE))
                      && (count_reg != '0);

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            apq_pkg::ST_IDLE: begin
                if (s_tvalid) state_next = apq_pkg::ST_EXEC;
            end
            apq_pkg::ST_EXEC: begin
                if (is_scan) state_next = apq_pkg::ST_SCAN;
                else if (out_free) state_next = apq_pkg::ST_IDLE;
            end
            apq_pkg::ST_SCAN: begin
                if (tok_valid[DEPTH]) state_next = apq_pkg::ST_DONE;
            end
            apq_pkg::ST_DONE: begin
                if (out_free) state_next = apq_pkg::ST_IDLE;
            end
            default: state_next = apq_pkg::ST_IDLE;
        endcase
    end

    // control strobes
    always_comb begin
        take_in    = 1'b0;
        imm_fin    = 1'b0;
        start_scan = 1'b0;
        done_fin   = 1'b0;
        unique case (state_reg)
            apq_pkg::ST_IDLE: take_in    = s_tvalid;
            apq_pkg::ST_EXEC: begin
                start_scan = is_scan;
                imm_fin    = !is_scan && out_free;
            end
            apq_pkg::ST_SCAN: ;
            apq_pkg::ST_DONE: done_fin   = out_free;
            default: ;
        endcase
    end

    assign s_tready  = (state_reg == apq_pkg::ST_IDLE);
    assign do_insert = imm_fin && (op_reg == apq_pkg::FUNC_INSERT) && !full;
    assign do_shift  = done_fin && (op_reg == apq_pkg::FUNC_DELETE);

    // result of the current request
    always_comb begin
        res_status = apq_pkg::STATUS_OK;
        res_val    = '0;
        res_pri    = '0;
        res_count  = count_reg;
        if (done_fin) begin
            res_pri = best_pri_reg;
            if (op_reg == apq_pkg::FUNC_DELETE) begin
                res_val   = best_val_reg;
                res_count = count_reg - CNT_W'(1);
            end
        end else begin
            case (op_reg) inside
                apq_pkg::FUNC_INSERT: begin
                    if (full) res_status = apq_pkg::STATUS_FULL;
                    else res_count = count_reg + CNT_W'(1);
                end
                apq_pkg::FUNC_PEEK, apq_pkg::FUNC_DELETE: res_status = apq_pkg::STATUS_EMPTY;
                default: ;
            endcase
        end
    end

    assign res_count_ext = {4'b0000, res_count};

    always_comb begin
        count_next   = count_reg;
        m_valid_next = m_valid_reg && !m_tready;
        m_data_next  = m_data_reg;
        if (imm_fin || done_fin) begin
            count_next   = res_count;
            m_valid_next = 1'b1;
            m_data_next  = '0;
            m_data_next[1:0]   = res_status;
            m_data_next[33:2]  = res_val;
            m_data_next[49:34] = res_pri;
            m_data_next[53:50] = res_count_ext[3:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= apq_pkg::ST_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
        if (take_in) begin
            op_reg  <= apq_pkg::func_t'(s_tdata[1:0]);
            val_reg <= s_tdata[33:2];
            pri_reg <= s_tdata[49:34];
        end
        if (tok_valid[DEPTH]) begin
            best_val_reg <= tok_val[DEPTH];
            best_pri_reg <= tok_pri[DEPTH];
            best_idx_reg <= tok_idx[DEPTH];
        end
    end

    assign tok_valid[0] = start_scan;
    assign tok_found[0] = 1'b0;
    assign tok_val[0]   = '0;
    assign tok_pri[0]   = '0;
    assign tok_idx[0]   = '0;

    for (genvar k = 0; k < DEPTH; k++) begin : g_cell
        logic [VW-1:0] nb_val;
        logic [PW-1:0] nb_pri;

        if (k == DEPTH - 1) begin : g_last
            assign nb_val = '0;
            assign nb_pri = '0;
        end else begin : g_mid
            assign nb_val = ent_val[k+1];
            assign nb_pri = ent_pri[k+1];
        end

        apq_cell #(
            .IDX_W (IDX_W),
            .INDEX (k)
        ) u_cell (
            .aclk          (aclk),
            .aresetn       (aresetn),
            .occ           (CNT_W'(k) < count_reg),
            .wr_en         (do_insert && (count_reg == CNT_W'(k))),
            .wr_val        (val_reg),
            .wr_pri        (pri_reg),
            .sh_en         (do_shift && (IDX_W'(k) >= best_idx_reg)),
            .sh_val        (nb_val),
            .sh_pri        (nb_pri),
            .ent_val       (ent_val[k]),
            .ent_pri       (ent_pri[k]),
            .tok_in_valid  (tok_valid[k]),
            .tok_in_found  (tok_found[k]),
            .tok_in_val    (tok_val[k]),
            .tok_in_pri    (tok_pri[k]),
            .tok_in_idx    (tok_idx[k]),
            .tok_out_valid (tok_valid[k+1]),
            .tok_out_found (tok_found[k+1]),
            .tok_out_val   (tok_val[k+1]),
            .tok_out_pri   (tok_pri[k+1]),
            .tok_out_idx   (tok_idx[k+1])
        );
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

FILE: dv/array_priority_queue_test.sv
// self-checking testbench for the array priority queue, directed table then random traffic
`timescale 1ns / 1ps

module array_priority_queue_test;

    localparam int DEPTH = 8;
    localparam int RANDOM_PER_PHASE = 463;
    localparam int SETTLE_CYCLES = DEPTH + 20;
    localparam logic [apq_pkg::FUNC_W-1:0] FUNC_UNUSED = 2'd3;

    typedef struct packed {
        logic [apq_pkg::STATUS_W-1:0] status;
        logic [apq_pkg::VALUE_W-1:0]  value;
        logic [apq_pkg::PRI_W-1:0]    pri;
        logic [apq_pkg::ECOUNT_W-1:0] count;
    } result_t;

    typedef struct packed {
        logic [apq_pkg::FUNC_W-1:0]  func;
        logic [apq_pkg::VALUE_W-1:0] value;
        logic [apq_pkg::PRI_W-1:0]   pri;
        logic                        typed;
        result_t                     want;
    } stim_row_t;

    localparam int DIRECTED_ROWS = 26;
    localparam stim_row_t DIRECTED [DIRECTED_ROWS] = '{
        '{apq_pkg::FUNC_PEEK,   32'h0000_0000, 16'h0000, 1'b1,
          '{apq_pkg::STATUS_EMPTY, 32'd0, 16'd0, 4'd0}},
        '{apq_pkg::FUNC_DELETE, 32'h0000_0000, 16'h0000, 1'b1,
          '{apq_pkg::STATUS_EMPTY, 32'd0, 16'd0, 4'd0}},
        '{FUNC_UNUSED,          32'hFFFF_FFFF, 16'hFFFF, 1'b1,
          '{apq_pkg::STATUS_OK,    32'd0, 16'd0, 4'd0}},
        '{apq_pkg::FUNC_INSERT, 32'h8000_0000, 16'h0000, 1'b1,
          '{apq_pkg::STATUS_OK,    32'd0, 16'd0, 4'd1}},
        '{apq_pkg::FUNC_INSERT, 32'h7FFF_FFFF, 16'hFFFF, 1'b1,
          '{apq_pkg::STATUS_OK,    32'd0, 16'd0, 4'd2}},
        '{apq_pkg::FUNC_INSERT, 32'hFFFF_FFFF, 16'hFFFF, 1'b1,
          '{apq_pkg::STATUS_OK,    32'd0, 16'd0, 4'd3}},
        '{apq_pkg::FUNC_PEEK,   32'h0000_0000, 16'h0000, 1'b0, '0},
        '{apq_pkg::FUNC_DELETE, 32'h0000_0000, 16'h0000, 1'b0, '0},
        '{apq_pkg::FUNC_INSERT, 32'h0000_0000, 16'h5555, 1'b0, '0},
        '{apq_pkg::FUNC_INSERT, 32'h0000_0001, 16'hAAAA, 1'b0, '0},
        '{apq_pkg::FUNC_INSERT, 32'h5555_5555, 16'h0001, 1'b0, '0},
        '{apq_pkg::FUNC_INSERT, 32'hAAAA_AAAA, 16'h8000, 1'b0, '0},
        '{apq_pkg::FUNC_INSERT, 32'h0000_3039, 16'h7FFF, 1'b0, '0},
        '{apq_pkg::FUNC_INSERT, 32'hFFFF_FFFE, 16'h0000, 1'b0, '0},
        '{apq_pkg::FUNC_INSERT, 32'h1357_2468, 16'h1234, 1'b1,
          '{apq_pkg::STATUS_FULL,  32'd0, 16'd0, 4'd8}},
        '{FUNC_UNUSED,          32'h0000_0000, 16'h0000, 1'b1,
          '{apq_pkg::STATUS_OK,    32'd0, 16'd0, 4'd8}},
        '{apq_pkg::FUNC_PEEK,   32'h0000_0000, 16'h0000, 1'b0, '0},
        '{apq_pkg::FUNC_DELETE, 32'h0000_0000, 16'h0000, 1'b0, '0},
        '{apq_pkg::FUNC_DELETE, 32'h0000_0000, 16'h0000, 1'b0, '0},
        '{apq_pkg::FUNC_DELETE, 32'h0000_0000, 16'h0000, 1'b0, '0},
        '{apq_pkg::FUNC_DELETE, 32'h0000_0000, 16'h0000, 1'b0, '0},
        '{apq_pkg::FUNC_DELETE, 32'h0000_0000, 16'h0000, 1'b0, '0},
        '{apq_pkg::FUNC_DELETE, 32'h0000_0000, 16'h0000, 1'b0, '0},
        '{apq_pkg::FUNC_DELETE, 32'h0000_0000, 16'h0000, 1'b0, '0},
        '{apq_pkg::FUNC_DELETE, 32'h0000_0000, 16'h0000, 1'b0, '0},
        '{apq_pkg::FUNC_DELETE, 32'h0000_0000, 16'h0000, 1'b1,
          '{apq_pkg::STATUS_EMPTY, 32'd0, 16'd0, 4'd0}}
    };

    logic                          aclk;
    logic                          aresetn  = 1'b0;
    logic                          s_tvalid = 1'b0;
    logic                          s_tready;
    logic [apq_pkg::S_TDATA_W-1:0] s_tdata  = '0;
    logic                          m_tvalid;
    logic                          m_tready = 1'b0;
    logic [apq_pkg::M_TDATA_W-1:0] m_tdata;

    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;
    int          mismatches     = 0;

    logic [apq_pkg::VALUE_W-1:0] held_values     [DEPTH];
    logic [apq_pkg::PRI_W-1:0]   held_priorities [DEPTH];
    int                          held_count = 0;
    result_t                     expected_results [$];

    array_priority_queue #(
        .DEPTH(DEPTH)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #5_000_000;
        $display("array_priority_queue_test failed");
        $finish;
    end

    // mirror of the queue: applies one request, returns the result it should give
    function automatic result_t apply_request(logic [apq_pkg::FUNC_W-1:0] func,
            logic [apq_pkg::VALUE_W-1:0] value, logic [apq_pkg::PRI_W-1:0] pri);
        result_t res;
        int      top;
        res = '0;
        if (func == apq_pkg::FUNC_INSERT) begin
            if (held_count >= DEPTH) begin
                res.status = apq_pkg::STATUS_FULL;
            end else begin
                held_values[held_count]     = value;
                held_priorities[held_count] = pri;
                held_count++;
            end
        end else if (func == apq_pkg::FUNC_PEEK || func == apq_pkg::FUNC_DELETE) begin
            if (held_count == 0) begin
                res.status = apq_pkg::STATUS_EMPTY;
            end else begin
                top = 0;
                // later entry wins a tie
                for (int i = 1; i < held_count; i++) begin
                    if (held_priorities[i] >= held_priorities[top]) top = i;
                end
                res.pri = held_priorities[top];
                if (func == apq_pkg::FUNC_DELETE) begin
                    res.value = held_values[top];
                    for (int j = top; j < held_count - 1; j++) begin
                        held_values[j]     = held_values[j + 1];
                        held_priorities[j] = held_priorities[j + 1];
                    end
                    held_count--;
                end
            end
        end
        res.count = held_count[apq_pkg::ECOUNT_W-1:0];
        return res;
    endfunction

    task automatic send_request(input logic [apq_pkg::FUNC_W-1:0] func,
            input logic [apq_pkg::VALUE_W-1:0] value, input logic [apq_pkg::PRI_W-1:0] pri,
            input logic typed, input result_t want);
        result_t predicted;
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {6'b0, pri, value, func};
        do @(posedge aclk); while (!s_tready);
        predicted = apply_request(func, value, pri);
        expected_results.push_back(typed ? want : predicted);
    endtask

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge aclk) begin
        result_t got;
        result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = '{m_tdata[1:0], m_tdata[33:2], m_tdata[49:34], m_tdata[53:50]};
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %h", $time, got);
                mismatches++;
            end else begin
                want = expected_results.pop_front();
                if (got.status !== want.status) begin
                    $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
                    mismatches++;
                end
                if (got.value !== want.value) begin
                    $display("%0t: out_value expected %h actual %h", $time, want.value, got.value);
                    mismatches++;
                end
                if (got.pri !== want.pri) begin
                    $display("%0t: out_priority expected %h actual %h", $time, want.pri, got.pri);
                    mismatches++;
                end
                if (got.count !== want.count) begin
                    $display("%0t: entry_count expected %0d actual %0d", $time, want.count,
                             got.count);
                    mismatches++;
                end
            end
        end
    end

    initial begin
        int unsigned send_pcts  [4];
        int unsigned stall_pcts [4];
        int unsigned mood;
        int unsigned r;
        int          issued;
        logic [apq_pkg::FUNC_W-1:0] func;
        logic [apq_pkg::PRI_W-1:0]  pri;

        send_pcts  = '{0, 69, 0, 7};
        stall_pcts = '{0, 0, 69, 7};

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        for (int n = 0; n < DIRECTED_ROWS; n++) begin
            send_request(DIRECTED[n].func, DIRECTED[n].value, DIRECTED[n].pri,
                         DIRECTED[n].typed, DIRECTED[n].want);
        end

        mood = 0;
        for (int phase = 0; phase < 4; phase++) begin
            send_idle_pct  = send_pcts[phase];
            recv_stall_pct = stall_pcts[phase];
            issued = 0;
            while (issued < RANDOM_PER_PHASE) begin
                // swing between filling, draining and mixed traffic
                if (issued % 24 == 0) mood = $urandom_range(2);
                r = $urandom_range(99);
                if (r < 3) begin
                    func = FUNC_UNUSED;
                end else if (r < (mood == 0 ? 78 : mood == 1 ? 28 : 50)) begin
                    func = apq_pkg::FUNC_INSERT;
                end else if (r < (mood == 0 ? 88 : mood == 1 ? 43 : 65)) begin
                    func = apq_pkg::FUNC_PEEK;
                end else begin
                    func = apq_pkg::FUNC_DELETE;
                end
                r = $urandom_range(99);
                if (r < 50) begin
                    pri = apq_pkg::PRI_W'($urandom_range(3));
                end else if (r < 80) begin
                    pri = apq_pkg::PRI_W'($urandom);
                end else begin
                    pri = $urandom_range(1) ? '1 : '0;
                end
                send_request(func, $urandom, pri, 1'b0, '0);
                issued++;
            end
        end
        s_tvalid <= 1'b0;

        while (expected_results.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);

        if (mismatches == 0) begin
            $display("array_priority_queue_test passed");
        end else begin
            $display("array_priority_queue_test failed");
        end
        $finish;
    end

endmodule
